>>> design/cst_pkg.sv
// Shared types and constants for the constant-strain triangle stress unit.
package cst_pkg;

   localparam int unsigned CoordW  = 32;
   localparam int unsigned DiffW   = 33;
   localparam int unsigned SumW    = 67;
   localparam int unsigned MagW    = 66;
   localparam int unsigned QuoW    = 32;
   localparam int unsigned CoefW   = 40;
   localparam int unsigned StressW = 64;
   localparam int unsigned IdxW    = 2;

   localparam logic [IdxW-1:0] RegDNormal = 2'd0;
   localparam logic [IdxW-1:0] RegDCross  = 2'd1;
   localparam logic [IdxW-1:0] RegDShear  = 2'd2;

   typedef struct packed {
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [31:0] x2;
      logic signed [31:0] y2;
      logic signed [31:0] ux0;
      logic signed [31:0] uy0;
      logic signed [31:0] ux1;
      logic signed [31:0] uy1;
      logic signed [31:0] ux2;
      logic signed [31:0] uy2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] strain_xx;
      logic signed [31:0] strain_yy;
      logic signed [31:0] shear_strain;
      logic signed [63:0] stress_xx;
      logic signed [63:0] stress_yy;
      logic signed [63:0] stress_xy;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 degenerate;
      logic [2:0]           negative;
   } side_type;

   typedef struct packed {
      side_type             side;
      logic [MagW-1:0]      num_xx;
      logic [MagW-1:0]      num_yy;
      logic [MagW-1:0]      num_gm;
      logic [MagW-1:0]      den;
   } geom_type;

endpackage

>>> design/cst_geom.sv
// Front end: edge differences, products, numerator and area sums, magnitudes.
module cst_geom (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cst_pkg::req_type in_data,
   output cst_pkg::geom_type out_geom
);

   logic [3:0] vld_ff;

   logic signed [32:0] b0_ff, b1_ff, b2_ff, c0_ff, c1_ff, c2_ff;
   logic signed [31:0] u0_ff, v0_ff, u1_ff, v1_ff, u2_ff, v2_ff;

   logic signed [65:0] pa_ff, pb_ff;
   logic signed [63:0] pb0u_ff, pb1u_ff, pb2u_ff, pc0v_ff, pc1v_ff, pc2v_ff;
   logic signed [63:0] pc0u_ff, pc1u_ff, pc2u_ff, pb0v_ff, pb1v_ff, pb2v_ff;

   logic signed [66:0] nxx_ff, nyy_ff, ngm_ff, den_ff;
   cst_pkg::geom_type  geom_ff;

   logic signed [64:0] m_b0u, m_b1u, m_b2u, m_c0v, m_c1v, m_c2v;
   logic signed [64:0] m_c0u, m_c1u, m_c2u, m_b0v, m_b1v, m_b2v;
   logic signed [66:0] nxx_in, nyy_in, ngm_in, den_in;
   logic [66:0]        a_xx, a_yy, a_gm, a_den;

   function automatic logic signed [32:0] diff(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      diff = $signed({a[31], a}) - $signed({b[31], b});
   endfunction

   function automatic logic [66:0] mag(input logic signed [66:0] v);
      mag = v[66] ? 67'(-v) : 67'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   assign m_b0u = 65'(b0_ff) * 65'(u0_ff);
   assign m_b1u = 65'(b1_ff) * 65'(u1_ff);
   assign m_b2u = 65'(b2_ff) * 65'(u2_ff);
   assign m_c0v = 65'(c0_ff) * 65'(v0_ff);
   assign m_c1v = 65'(c1_ff) * 65'(v1_ff);
   assign m_c2v = 65'(c2_ff) * 65'(v2_ff);
   assign m_c0u = 65'(c0_ff) * 65'(u0_ff);
   assign m_c1u = 65'(c1_ff) * 65'(u1_ff);
   assign m_c2u = 65'(c2_ff) * 65'(u2_ff);
   assign m_b0v = 65'(b0_ff) * 65'(v0_ff);
   assign m_b1v = 65'(b1_ff) * 65'(v1_ff);
   assign m_b2v = 65'(b2_ff) * 65'(v2_ff);

   assign nxx_in = 67'(pb0u_ff) + 67'(pb1u_ff) + 67'(pb2u_ff);
   assign nyy_in = 67'(pc0v_ff) + 67'(pc1v_ff) + 67'(pc2v_ff);
   assign ngm_in = 67'(pc0u_ff) + 67'(pc1u_ff) + 67'(pc2u_ff)
                 + 67'(pb0v_ff) + 67'(pb1v_ff) + 67'(pb2v_ff);
   assign den_in = 67'(pa_ff) - 67'(pb_ff);

   assign a_xx  = mag(nxx_ff);
   assign a_yy  = mag(nyy_ff);
   assign a_gm  = mag(ngm_ff);
   assign a_den = mag(den_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         b0_ff <= diff(in_data.y1, in_data.y2);
         b1_ff <= diff(in_data.y2, in_data.y0);
         b2_ff <= diff(in_data.y0, in_data.y1);
         c0_ff <= diff(in_data.x2, in_data.x1);
         c1_ff <= diff(in_data.x0, in_data.x2);
         c2_ff <= diff(in_data.x1, in_data.x0);
         u0_ff <= in_data.ux0;
         v0_ff <= in_data.uy0;
         u1_ff <= in_data.ux1;
         v1_ff <= in_data.uy1;
         u2_ff <= in_data.ux2;
         v2_ff <= in_data.uy2;

         pa_ff   <= 66'(c2_ff) * 66'(b1_ff);
         pb_ff   <= 66'(c1_ff) * 66'(b2_ff);
         pb0u_ff <= m_b0u[63:0];
         pb1u_ff <= m_b1u[63:0];
         pb2u_ff <= m_b2u[63:0];
         pc0v_ff <= m_c0v[63:0];
         pc1v_ff <= m_c1v[63:0];
         pc2v_ff <= m_c2v[63:0];
         pc0u_ff <= m_c0u[63:0];
         pc1u_ff <= m_c1u[63:0];
         pc2u_ff <= m_c2u[63:0];
         pb0v_ff <= m_b0v[63:0];
         pb1v_ff <= m_b1v[63:0];
         pb2v_ff <= m_b2v[63:0];

         nxx_ff <= nxx_in;
         nyy_ff <= nyy_in;
         ngm_ff <= ngm_in;
         den_ff <= den_in;

         geom_ff.side.valid      <= vld_ff[2];
         geom_ff.side.degenerate <= (den_ff == '0);
         geom_ff.side.negative   <= {ngm_ff[66] ^ den_ff[66], nyy_ff[66] ^ den_ff[66],
                                     nxx_ff[66] ^ den_ff[66]};
         geom_ff.num_xx <= a_xx[65:0];
         geom_ff.num_yy <= a_yy[65:0];
         geom_ff.num_gm <= a_gm[65:0];
         geom_ff.den    <= a_den[65:0];
      end
   end

   always_comb begin
      out_geom            = geom_ff;
      out_geom.side.valid = vld_ff[3];
   end

endmodule

>>> design/cst_div.sv
// Pipelined restoring divider: 32 quotient bits of (num * 2^16) / den, one per stage.
module cst_div (
   input  logic        clock,
   input  logic        en,
   input  logic [65:0] num,
   input  logic [65:0] den,
   output logic [31:0] quo,
   output logic        ovf
);

   logic [65:0] rem_ff [0:32];
   logic [65:0] den_ff [0:32];
   logic [31:0] low_ff [0:32];
   logic [31:0] quo_ff [0:32];
   logic        ovf_ff [0:32];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {16'd0, num[65:16]};
         den_ff[0] <= den;
         low_ff[0] <= {num[15:0], 16'd0};
         quo_ff[0] <= '0;
         ovf_ff[0] <= ({16'd0, num[65:16]} >= den);
      end
   end

   for (genvar k = 0; k < 32; k++) begin : g_step
      logic [66:0] trial;
      logic [66:0] diff;
      logic        ge;

      assign trial = {rem_ff[k], low_ff[k][31]};
      assign diff  = trial - {1'b0, den_ff[k]};
      assign ge    = (trial >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[65:0] : trial[65:0];
            den_ff[k+1] <= den_ff[k];
            low_ff[k+1] <= {low_ff[k][30:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][30:0], ge};
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign quo = quo_ff[32];
   assign ovf = ovf_ff[32];

endmodule

>>> design/cst_stress.sv
// Back end: strain sign and saturation, material products, stress rounding and saturation.
module cst_stress (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  cst_pkg::side_type side,
   input  logic [31:0]       quo_xx,
   input  logic [31:0]       quo_yy,
   input  logic [31:0]       quo_gm,
   input  logic [2:0]        ovf,
   input  logic [39:0]       d_normal,
   input  logic [39:0]       d_cross,
   input  logic [39:0]       d_shear,
   output logic              out_valid,
   output cst_pkg::rsp_type  out_data
);

   logic [2:0]         vld_ff;
   logic               deg1_ff, deg2_ff;
   logic signed [31:0] exx_ff, eyy_ff, egm_ff;
   logic signed [31:0] exx2_ff, eyy2_ff, egm2_ff;
   logic signed [72:0] p_nx_ff, p_cy_ff, p_cx_ff, p_ny_ff, p_sg_ff;
   cst_pkg::rsp_type   rsp_ff;

   function automatic logic [31:0] sat_strain(input logic [31:0] q, input logic o,
                                              input logic neg, input logic deg);
      logic [31:0] r;
      if (deg) begin
         r = '0;
      end else if (!neg) begin
         r = (o || q[31]) ? 32'h7FFF_FFFF : q;
      end else begin
         r = (o || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      end
      sat_strain = r;
   endfunction

   function automatic logic [63:0] sat_stress(input logic signed [72:0] a,
                                              input logic signed [72:0] b);
      logic signed [73:0] s;
      logic [65:0]        sh;
      logic [63:0]        r;
      s  = {a[72], a} + {b[72], b};
      sh = s[73:8];
      if (sh[65:63] == 3'b000 || sh[65:63] == 3'b111) begin
         r = sh[63:0];
      end else if (sh[65]) begin
         r = 64'h8000_0000_0000_0000;
      end else begin
         r = 64'h7FFF_FFFF_FFFF_FFFF;
      end
      sat_stress = r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], side.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exx_ff  <= sat_strain(quo_xx, ovf[0], side.negative[0], side.degenerate);
         eyy_ff  <= sat_strain(quo_yy, ovf[1], side.negative[1], side.degenerate);
         egm_ff  <= sat_strain(quo_gm, ovf[2], side.negative[2], side.degenerate);
         deg1_ff <= side.degenerate;

         p_nx_ff <= 73'($signed({1'b0, d_normal})) * 73'(exx_ff);
         p_cy_ff <= 73'($signed({1'b0, d_cross})) * 73'(eyy_ff);
         p_cx_ff <= 73'($signed({1'b0, d_cross})) * 73'(exx_ff);
         p_ny_ff <= 73'($signed({1'b0, d_normal})) * 73'(eyy_ff);
         p_sg_ff <= 73'($signed({1'b0, d_shear})) * 73'(egm_ff);
         exx2_ff <= exx_ff;
         eyy2_ff <= eyy_ff;
         egm2_ff <= egm_ff;
         deg2_ff <= deg1_ff;

         rsp_ff.strain_xx    <= exx2_ff;
         rsp_ff.strain_yy    <= eyy2_ff;
         rsp_ff.shear_strain <= egm2_ff;
         rsp_ff.stress_xx    <= sat_stress(p_nx_ff, p_cy_ff);
         rsp_ff.stress_yy    <= sat_stress(p_cx_ff, p_ny_ff);
         rsp_ff.stress_xy    <= sat_stress(p_sg_ff, '0);
         rsp_ff.degenerate   <= deg2_ff;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_data  = rsp_ff;

endmodule

>>> design/cst_element_stress_unit.sv
// Top level of the constant-strain triangle stress unit.
//
//   channel | ports                       | width    | direction
//   req     | req_valid req_ready req_data | req_type | in
//   rsp     | rsp_valid rsp_ready rsp_data | rsp_type | out
//   csr     | csr_we csr_index csr_wdata   | 2 / 40   | in
//
// One transaction per cycle while the pipeline advances. Stages: 4 front-end, 33 divider
// (load, then one quotient bit each) and 3 back-end, ending in the output register.
// Reset clears all valid bits and the material coefficients.
// The pipeline advances as one whole whenever the output register is empty or taken.
module cst_element_stress_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cst_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [39:0]      csr_wdata
);

   logic [39:0]       d_normal_ff, d_cross_ff, d_shear_ff;
   logic              en;
   cst_pkg::geom_type geom;
   cst_pkg::side_type side_ff [0:32];
   logic [31:0]       quo_xx, quo_yy, quo_gm;
   logic [2:0]        ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_normal_ff <= '0;
         d_cross_ff  <= '0;
         d_shear_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cst_pkg::RegDNormal: d_normal_ff <= csr_wdata;
            cst_pkg::RegDCross:  d_cross_ff  <= csr_wdata;
            cst_pkg::RegDShear:  d_shear_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   cst_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_geom (geom)
   );

   cst_div u_div_xx (.clock(clock), .en(en), .num(geom.num_xx), .den(geom.den),
                     .quo(quo_xx), .ovf(ovf[0]));
   cst_div u_div_yy (.clock(clock), .en(en), .num(geom.num_yy), .den(geom.den),
                     .quo(quo_yy), .ovf(ovf[1]));
   cst_div u_div_gm (.clock(clock), .en(en), .num(geom.num_gm), .den(geom.den),
                     .quo(quo_gm), .ovf(ovf[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= 32; i++) begin
            side_ff[i] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= geom.side;
         for (int i = 1; i <= 32; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   cst_stress u_stress (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .side      (side_ff[32]),
      .quo_xx    (quo_xx),
      .quo_yy    (quo_yy),
      .quo_gm    (quo_gm),
      .ovf       (ovf),
      .d_normal  (d_normal_ff),
      .d_cross   (d_cross_ff),
      .d_shear   (d_shear_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

>>> verif/cst_element_stress_unit_tb.sv
// Self-checking testbench for the constant-strain triangle stress unit.
module cst_element_stress_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cst_pkg::IdxW-1:0] RegUnused = 2'd3;
   localparam int unsigned     CycleLimit = 200000;
   localparam logic [39:0]     CoefMax = 40'hFF_FFFF_FFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cst_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cst_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [39:0]      csr_wdata = '0;

   cst_pkg::req_type triangles_pending[$];
   cst_pkg::rsp_type stress_expected[$];
   logic [39:0] coef_normal = '0, coef_cross = '0, coef_shear = '0;
   logic        req_taken = 1'b0;
   logic        calm = 1'b0;
   logic        stalled_once = 1'b0;
   int          hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;
   int unsigned degenerate_count = 0;
   int unsigned error_count = 0;

   cst_element_stress_unit dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic signed [31:0] strain_of(logic signed [127:0] num,
                                                    logic signed [127:0] den);
      logic signed [127:0] q;
      q = (num <<< 16) / den;
      if (q > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (q < -128'sh8000_0000) return 32'sh8000_0000;
      return q[31:0];
   endfunction

   function automatic logic signed [63:0] stress_of(logic signed [127:0] acc);
      logic signed [127:0] s;
      s = acc >>> 8;
      if (s > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   function automatic cst_pkg::rsp_type element_stress(cst_pkg::req_type t);
      logic signed [127:0] x0, y0, x1, y1, x2, y2, u0, v0, u1, v1, u2, v2;
      logic signed [127:0] b0, b1, b2, c0, c1, c2, area2, nxx, nyy, ngm;
      logic signed [127:0] dn, dc, ds;
      cst_pkg::rsp_type r;
      r = '0;
      x0 = t.x0; y0 = t.y0; x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2;
      u0 = t.ux0; v0 = t.uy0; u1 = t.ux1; v1 = t.uy1; u2 = t.ux2; v2 = t.uy2;
      dn = {88'b0, coef_normal};
      dc = {88'b0, coef_cross};
      ds = {88'b0, coef_shear};
      area2 = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
      if (area2 == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      b0 = y1 - y2; b1 = y2 - y0; b2 = y0 - y1;
      c0 = x2 - x1; c1 = x0 - x2; c2 = x1 - x0;
      nxx = b0 * u0 + b1 * u1 + b2 * u2;
      nyy = c0 * v0 + c1 * v1 + c2 * v2;
      ngm = c0 * u0 + c1 * u1 + c2 * u2 + b0 * v0 + b1 * v1 + b2 * v2;
      r.strain_xx    = strain_of(nxx, area2);
      r.strain_yy    = strain_of(nyy, area2);
      r.shear_strain = strain_of(ngm, area2);
      r.stress_xx = stress_of(dn * r.strain_xx + dc * r.strain_yy);
      r.stress_yy = stress_of(dc * r.strain_xx + dn * r.strain_yy);
      r.stress_xy = stress_of(ds * r.shear_strain);
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s at transaction %0d: got %h expected %h",
               what, checked_count, got, want);
      error_count++;
   endtask

   task automatic queue_triangle(cst_pkg::req_type t);
      triangles_pending = {triangles_pending, t};
   endtask

   // Request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (triangles_pending.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
            req_valid <= 1'b1;
            req_data  <= triangles_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!stalled_once && accepted_count >= 600) begin
         stalled_once <= 1'b1;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 15;
      end
   end

   // Monitor
   always @(posedge clock) begin
      cst_pkg::rsp_type want;
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         stress_expected = {stress_expected, element_stress(req_data)};
         accepted_count <= accepted_count + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (stress_expected.size() == 0) begin
            $display("unexpected transaction on the response channel");
            error_count++;
         end else begin
            want = stress_expected.pop_front();
            if (rsp_data.strain_xx !== want.strain_xx)
               report("strain_xx", rsp_data.strain_xx, want.strain_xx);
            if (rsp_data.strain_yy !== want.strain_yy)
               report("strain_yy", rsp_data.strain_yy, want.strain_yy);
            if (rsp_data.shear_strain !== want.shear_strain)
               report("shear_strain", rsp_data.shear_strain, want.shear_strain);
            if (rsp_data.stress_xx !== want.stress_xx)
               report("stress_xx", rsp_data.stress_xx, want.stress_xx);
            if (rsp_data.stress_yy !== want.stress_yy)
               report("stress_yy", rsp_data.stress_yy, want.stress_yy);
            if (rsp_data.stress_xy !== want.stress_xy)
               report("stress_xy", rsp_data.stress_xy, want.stress_xy);
            if (rsp_data.degenerate !== want.degenerate)
               report("degenerate", rsp_data.degenerate, want.degenerate);
            if (want.degenerate) degenerate_count++;
            checked_count++;
         end
      end
   end

   task automatic write_coef(logic [cst_pkg::IdxW-1:0] idx, logic [39:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         cst_pkg::RegDNormal: coef_normal = value;
         cst_pkg::RegDCross:  coef_cross  = value;
         cst_pkg::RegDShear:  coef_shear  = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(negedge clock);
      while (triangles_pending.size() > 0 || req_valid || stress_expected.size() > 0);
      repeat (45) @(negedge clock);
   endtask

   function automatic cst_pkg::req_type make_triangle(int unsigned kind);
      cst_pkg::req_type t;
      logic [31:0] w[12];
      foreach (w[i]) w[i] = $urandom;
      t = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]};
      case (kind)
         0: ;
         1, 2, 3: begin
            // well-shaped element, moderate displacements
            t.x0 = $signed(w[0]) >>> 6;  t.y0 = $signed(w[1]) >>> 6;
            t.x1 = $signed(w[2]) >>> 6;  t.y1 = $signed(w[3]) >>> 6;
            t.x2 = $signed(w[4]) >>> 6;  t.y2 = $signed(w[5]) >>> 6;
            t.ux0 = $signed(w[6]) >>> 8;  t.uy0 = $signed(w[7]) >>> 8;
            t.ux1 = $signed(w[8]) >>> 8;  t.uy1 = $signed(w[9]) >>> 8;
            t.ux2 = $signed(w[10]) >>> 8; t.uy2 = $signed(w[11]) >>> 8;
         end
         4: begin
            // collinear nodes
            t.x2 = t.x0 + (t.x1 - t.x0) * 2;
            t.y2 = t.y0 + (t.y1 - t.y0) * 2;
            if ($urandom_range(1)) begin t.x1 = t.x0; t.y1 = t.y0; end
         end
         default: begin
            // small element, tiny displacements
            t.x1 = t.x0 + $signed(w[2][15:0]);
            t.y1 = t.y0 + $signed(w[3][15:0]);
            t.x2 = t.x0 + $signed(w[4][15:0]);
            t.y2 = t.y0 + $signed(w[5][15:0]);
            t.ux0 = $signed(w[6]) >>> 20; t.uy0 = $signed(w[7]) >>> 20;
            t.ux1 = $signed(w[8]) >>> 20; t.uy1 = $signed(w[9]) >>> 20;
            t.ux2 = $signed(w[10]) >>> 20; t.uy2 = $signed(w[11]) >>> 20;
         end
      endcase
      return t;
   endfunction

   initial begin
      cst_pkg::req_type t;
      logic signed [31:0] mx, mn, one;
      mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000; one = 32'sh0001_0000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_coef(cst_pkg::RegDNormal, 40'd100 << 8);
      write_coef(cst_pkg::RegDCross, 40'd30 << 8);
      write_coef(cst_pkg::RegDShear, 40'd35 << 8);
      write_coef(RegUnused, CoefMax);

      // directed elements
      t = '0; queue_triangle(t);
      t = {12{mx}}; queue_triangle(t);
      t = {12{mn}}; queue_triangle(t);
      t = '0; t.x1 = one; t.y2 = one; t.ux1 = 32'sh0000_1000; t.uy2 = -32'sh0000_2000;
      queue_triangle(t);
      t.x1 = '0; t.y1 = one; t.x2 = one; t.y2 = '0; queue_triangle(t);
      t = '0; t.x1 = one; t.y2 = one; t.ux1 = mx; t.uy2 = mn; t.ux2 = mn;
      queue_triangle(t);
      t = '0; t.x0 = mn; t.y0 = mn; t.x1 = mx; t.y1 = mn; t.x2 = mn; t.y2 = mx;
      t.ux1 = 32'sh0100_0000; t.uy2 = 32'sh0100_0000; queue_triangle(t);
      t.x1 = mn + 1; t.y2 = mn + 1; t.ux1 = mx; t.uy0 = mn; t.uy2 = mx;
      queue_triangle(t);
      t = '0; t.x1 = one; t.x2 = 2 * one; t.ux0 = mx; queue_triangle(t);
      t = '0; t.x0 = mx; t.y0 = mx; t.x1 = mx; t.y1 = mx; t.x2 = mx; t.y2 = mx;
      queue_triangle(t);
      repeat (8) queue_triangle(make_triangle($urandom_range(5)));
      drain();

      calm = 1'b1;
      for (int i = 0; i < 400; i++)
         queue_triangle(make_triangle($urandom_range(5)));
      drain();
      calm = 1'b0;

      write_coef(cst_pkg::RegDNormal, CoefMax);
      write_coef(cst_pkg::RegDCross, CoefMax);
      write_coef(cst_pkg::RegDShear, CoefMax);
      for (int i = 0; i < 400; i++)
         queue_triangle(make_triangle($urandom_range(5)));
      drain();

      write_coef(cst_pkg::RegDNormal, '0);
      write_coef(cst_pkg::RegDCross, '0);
      write_coef(cst_pkg::RegDShear, '0);
      for (int i = 0; i < 300; i++)
         queue_triangle(make_triangle($urandom_range(5)));
      drain();

      for (int p = 0; p < 3; p++) begin
         write_coef(cst_pkg::RegDNormal,
                    40'({$urandom, $urandom} >> (24 + $urandom_range(24))));
         write_coef(cst_pkg::RegDCross,
                    40'({$urandom, $urandom} >> (24 + $urandom_range(24))));
         write_coef(cst_pkg::RegDShear,
                    40'({$urandom, $urandom} >> (24 + $urandom_range(24))));
         write_coef(RegUnused, 40'({$urandom, $urandom}));
         for (int i = 0; i < 300; i++)
            queue_triangle(make_triangle($urandom_range(5)));
         drain();
      end

      $display("checked %0d elements (%0d degenerate), %0d mismatches",
               checked_count, degenerate_count, error_count);
      $display("coefficient sets covered zero, full scale and random values");
      if (error_count == 0 && stress_expected.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
